// ===== hdl/bled_pkg.sv =====
// Shared types, widths and codes for the breathing RGB LED envelope.
package bled_pkg;

	// Field and datapath widths
	localparam int LEVEL_W   = 8;
	localparam int STEP_W    = 9;
	localparam int TICK_W    = 16;
	localparam int CAL_W     = 11;
	localparam int DUTY_W    = 10;
	localparam int NUM_W     = 20;
	localparam int DIV_CNT_W = 4;
	localparam int NUM_CH    = 3;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;

	// Level divisor used to map an 8-bit level onto the calibrated compare range
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'hFF;

	// Item kinds
	localparam logic KIND_COLOUR = 1'b0;
	localparam logic KIND_TICK   = 1'b1;

	// Register map index (byte address / 4)
	typedef enum logic [2:0] {
		REG_RAMP_IN   = 3'd0,
		REG_RAMP_OUT  = 3'd1,
		REG_HOLD      = 3'd2,
		REG_WAIT      = 3'd3,
		REG_RED_CAL   = 3'd4,
		REG_GREEN_CAL = 3'd5,
		REG_BLUE_CAL  = 3'd6
	} reg_idx_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RMUL,
		ST_RDIV,
		ST_SMUL,
		ST_SDIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic               kind;
		logic [LEVEL_W-1:0] red_level;
		logic [LEVEL_W-1:0] green_level;
		logic [LEVEL_W-1:0] blue_level;
	} in_item_t;

	typedef struct packed {
		logic [DUTY_W-1:0] red_duty;
		logic [DUTY_W-1:0] green_duty;
		logic [DUTY_W-1:0] blue_duty;
		logic              lit;
	} out_item_t;

	// Divider handshake back to the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

// ===== hdl/breathing_rgb_led_envelope.sv =====
// Breathing RGB LED envelope: animation sequencer, serial scaling and register port.
//
//  channel | direction | handshake             | beat
//  --------+-----------+-----------------------+---------------------------------
//  in      | input     | in_valid / in_stall   | in_item_t: kind, three levels
//  out     | output    | out_valid / out_stall | out_item_t: three duties, lit
//  apb     | input     | psel / penable        | 32-bit register write and read
//
// Every result runs one scaling division per channel through the shared divider; a ramp
// step first runs a ramp division per channel, which zero color, full and dark steps skip.
// Each division yields two quotient bits per cycle, the three channels in turn.
// A tick that causes no result starts no division. arst_n clears the sequencer, the output
// valid flag and the configuration to its defaults. The next beat is taken while a result
// waits on a stalled output; a second result then holds until the first one leaves.
module breathing_rgb_led_envelope import bled_pkg::*; #(
	parameter int PWM_PERIOD = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_stall,
	input  in_item_t          in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output out_item_t         out_data
);

	localparam int DUTY_CAP = (PWM_PERIOD - 1 > 1023) ? 1023 : PWM_PERIOD - 1;
	localparam logic [NUM_W-1:0] CAP_WIDE = NUM_W'(DUTY_CAP);
	localparam logic [1:0] LAST_CH = 2'(NUM_CH - 1);

	// Configuration
	logic [LEVEL_W-1:0] ramp_in_q, ramp_out_q;
	logic [TICK_W-1:0]  hold_q, wait_q;
	logic [CAL_W-1:0]   cal_q [NUM_CH];

	// Animation state
	logic               running_q;
	logic [STEP_W-1:0]  step_q;
	logic [TICK_W-1:0]  ticks_q;
	logic [LEVEL_W-1:0] stored_q [NUM_CH];

	// Per-item working registers
	state_t             state_q, state_d;
	logic [1:0]         ch_q;
	logic [STEP_W-1:0]  mult_q;
	logic [LEVEL_W-1:0] rdiv_q;
	logic [LEVEL_W-1:0] level_q [NUM_CH];
	logic [DUTY_W-1:0]  duty_q [NUM_CH];
	logic               out_valid_q;
	out_item_t          out_q;

	// Divider hookup
	logic               div_start;
	logic [NUM_W-1:0]   div_numer;
	logic [LEVEL_W-1:0] div_denom;
	div_status_t        div_st;
	logic [NUM_W-1:0]   div_quot;

	// Decode of the offered beat
	logic               in_fire, is_colour, colour_zero, tick_due, do_step, has_result;
	logic [STEP_W-1:0]  c_eff, sum_io, mult_d;
	logic               rise, full, fall;
	logic [LEVEL_W-1:0] col [NUM_CH];
	logic [CAL_W-1:0]   cal_m1;
	logic [DUTY_W-1:0]  duty_sat;
	logic               cfg_wr, out_free;
	reg_idx_t           reg_idx;

	bled_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (div_numer),
		.denom  (div_denom),
		.status (div_st),
		.quot   (div_quot)
	);

	// Register port
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[4:2]);
	assign cfg_wr  = psel & penable & pwrite;

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_RAMP_IN:   prdata = DATA_W'(ramp_in_q);
			REG_RAMP_OUT:  prdata = DATA_W'(ramp_out_q);
			REG_HOLD:      prdata = DATA_W'(hold_q);
			REG_WAIT:      prdata = DATA_W'(wait_q);
			REG_RED_CAL:   prdata = DATA_W'(cal_q[0]);
			REG_GREEN_CAL: prdata = DATA_W'(cal_q[1]);
			REG_BLUE_CAL:  prdata = DATA_W'(cal_q[2]);
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_in_q  <= 8'd60;
			ramp_out_q <= 8'd60;
			hold_q     <= 16'd30;
			wait_q     <= 16'd150;
			cal_q[0]   <= 11'd1024;
			cal_q[1]   <= 11'd1024;
			cal_q[2]   <= 11'd1024;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_RAMP_IN:   ramp_in_q  <= pwdata[LEVEL_W-1:0];
				REG_RAMP_OUT:  ramp_out_q <= pwdata[LEVEL_W-1:0];
				REG_HOLD:      hold_q     <= pwdata[TICK_W-1:0];
				REG_WAIT:      wait_q     <= pwdata[TICK_W-1:0];
				REG_RED_CAL:   cal_q[0]   <= pwdata[CAL_W-1:0];
				REG_GREEN_CAL: cal_q[1]   <= pwdata[CAL_W-1:0];
				REG_BLUE_CAL:  cal_q[2]   <= pwdata[CAL_W-1:0];
				default: ;
			endcase
		end
	end

	// Classify the beat and the animation step it takes
	assign in_stall    = (state_q != ST_IDLE);
	assign in_fire     = in_valid & ~in_stall;
	assign is_colour   = (in_data.kind == KIND_COLOUR);
	assign colour_zero = (in_data.red_level == '0) && (in_data.green_level == '0)
		&& (in_data.blue_level == '0);
	assign tick_due    = running_q && (ticks_q <= TICK_W'(1));
	assign do_step     = is_colour ? ~colour_zero : tick_due;
	assign has_result  = is_colour | do_step;

	assign c_eff  = is_colour ? '0 : step_q;
	assign sum_io = STEP_W'(ramp_in_q) + STEP_W'(ramp_out_q);
	assign rise   = (c_eff < STEP_W'(ramp_in_q));
	assign full   = (c_eff == STEP_W'(ramp_in_q));
	assign fall   = ~rise & ~full & (c_eff <= sum_io);
	assign mult_d = rise ? c_eff : STEP_W'(sum_io - c_eff);

	assign col[0] = is_colour ? in_data.red_level   : stored_q[0];
	assign col[1] = is_colour ? in_data.green_level : stored_q[1];
	assign col[2] = is_colour ? in_data.blue_level  : stored_q[2];

	// Scaling operands and saturation
	assign cal_m1   = (cal_q[ch_q] == '0) ? '0 : CAL_W'(cal_q[ch_q] - 1'b1);
	assign duty_sat = (div_quot > CAP_WIDE) ? CAP_WIDE[DUTY_W-1:0] : div_quot[DUTY_W-1:0];
	assign out_free = ~out_valid_q | ~out_stall;

	// Sequencer: next state and divider launch
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_numer = '0;
		div_denom = LEVEL_MAX;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && has_result)
					state_d = (do_step && (rise || fall)) ? ST_RMUL : ST_SMUL;
			end
			ST_RMUL: begin
				div_start = 1'b1;
				div_numer = NUM_W'(stored_q[ch_q] * mult_q);
				div_denom = rdiv_q;
				state_d   = ST_RDIV;
			end
			ST_RDIV: begin
				if (div_st.done)
					state_d = (ch_q == LAST_CH) ? ST_SMUL : ST_RMUL;
			end
			ST_SMUL: begin
				div_start = 1'b1;
				div_numer = NUM_W'(level_q[ch_q] * cal_m1);
				div_denom = LEVEL_MAX;
				state_d   = ST_SDIV;
			end
			ST_SDIV: begin
				if (div_st.done)
					state_d = (ch_q == LAST_CH) ? ST_EMIT : ST_SMUL;
			end
			ST_EMIT: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers: state, channel, animation, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= '0;
			running_q   <= 1'b0;
			step_q      <= '0;
			ticks_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EMIT && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if ((state_q == ST_RDIV || state_q == ST_SDIV) && div_st.done)
				ch_q <= (ch_q == LAST_CH) ? '0 : ch_q + 1'b1;
			if (in_fire) begin
				ch_q <= '0;
				if (is_colour) begin
					if (colour_zero) begin
						running_q <= 1'b0;
						step_q    <= '0;
						ticks_q   <= '0;
					end else begin
						running_q <= 1'b1;
					end
				end else if (running_q && !tick_due) begin
					ticks_q <= ticks_q - 1'b1;
				end
				// Take the step: ramps wait one tick, full waits hold, dark waits wait
				if (do_step) begin
					if (rise || fall) begin
						step_q  <= c_eff + 1'b1;
						ticks_q <= TICK_W'(1);
					end else if (full) begin
						step_q  <= c_eff + 1'b1;
						ticks_q <= (hold_q == '0) ? TICK_W'(1) : hold_q;
					end else begin
						step_q  <= '0;
						ticks_q <= (wait_q == '0) ? TICK_W'(1) : wait_q;
					end
				end
			end
		end
	end

	// Payload registers: color, ramp operands, levels, duties, output beat
	always_ff @(posedge clk) begin
		if (in_fire) begin
			if (is_colour && !colour_zero) begin
				stored_q[0] <= in_data.red_level;
				stored_q[1] <= in_data.green_level;
				stored_q[2] <= in_data.blue_level;
			end
			mult_q <= mult_d;
			rdiv_q <= rise ? ramp_in_q : ramp_out_q;
			for (int i = 0; i < NUM_CH; i++)
				level_q[i] <= (do_step && full) ? col[i] : '0;
		end
		if (state_q == ST_RDIV && div_st.done)
			level_q[ch_q] <= div_quot[LEVEL_W-1:0];
		if (state_q == ST_SDIV && div_st.done)
			duty_q[ch_q] <= duty_sat;
		if (state_q == ST_EMIT && out_free) begin
			out_q.red_duty   <= duty_q[0];
			out_q.green_duty <= duty_q[1];
			out_q.blue_duty  <= duty_q[2];
			out_q.lit        <= (level_q[0] != '0) || (level_q[1] != '0) || (level_q[2] != '0);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// A stopped animation has no pending countdown
	a_stopped_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!running_q |-> ticks_q == '0)
		else $error("countdown pending while animation stopped");

	// The divider is only launched when free
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_st.busy)
		else $error("divider launched while busy");

	// A dark result carries zero duties
	a_dark_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.lit |-> out_data.red_duty == '0
			&& out_data.green_duty == '0 && out_data.blue_duty == '0)
		else $error("nonzero duty on a dark result");

	// Duties never exceed the PWM compare limit
	a_duty_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.red_duty <= DUTY_W'(DUTY_CAP)
			&& out_data.green_duty <= DUTY_W'(DUTY_CAP)
			&& out_data.blue_duty <= DUTY_W'(DUTY_CAP))
		else $error("duty above compare limit");

	// A result leaves the sequencer only with the divider at rest
	a_emit_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> !div_st.busy && !div_start)
		else $error("divider active while emitting");

endmodule

// ===== hdl/bled_div.sv =====
// Radix-4 restoring divider: two quotient bits per cycle, 8-bit divisor.
module bled_div import bled_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [NUM_W-1:0]   numer,
	input  logic [LEVEL_W-1:0] denom,
	output div_status_t        status,
	output logic [NUM_W-1:0]   quot
);

	localparam logic [DIV_CNT_W-1:0] LAST_CNT = DIV_CNT_W'(NUM_W / 2 - 1);

	logic [NUM_W-1:0]     num_q;
	logic [LEVEL_W-1:0]   rem_q;
	logic [LEVEL_W-1:0]   den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [LEVEL_W:0]   t1, t2;
	logic               ge1, ge2;
	logic [LEVEL_W-1:0] r1, r2;

	// Two dependent shift-compare-subtract steps
	always_comb begin
		t1  = {rem_q, num_q[NUM_W-1]};
		ge1 = (t1 >= {1'b0, den_q});
		r1  = ge1 ? LEVEL_W'(t1 - {1'b0, den_q}) : t1[LEVEL_W-1:0];
		t2  = {r1, num_q[NUM_W-2]};
		ge2 = (t2 >= {1'b0, den_q});
		r2  = ge2 ? LEVEL_W'(t2 - {1'b0, den_q}) : t2[LEVEL_W-1:0];
	end

	// Control: count digit pairs, pulse done after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_CNT) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: numerator shifts out as quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= numer;
			rem_q <= '0;
			den_q <= denom;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-3:0], ge1, ge2};
			rem_q <= r2;
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quot        = num_q;

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for the breathing RGB LED envelope: duty prediction, stimulus and result checks.
`timescale 1ns / 100ps

module tb_top import bled_pkg::*; ();

	localparam int PWM_PERIOD     = 1024;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 120;
	localparam int RANDOM_PHASES  = 10;
	localparam int PHASE_BEATS    = 93;

	// Tracks the envelope animation and the duty results it still owes
	class envelope_board;
		int unsigned ramp_up, ramp_down, hold_len, dark_len;
		int unsigned full_scale [3];
		int unsigned duty_cap;
		bit          running;
		int unsigned step_no, ticks_left;
		int unsigned col_r, col_g, col_b;
		out_item_t   duties_due [$];
		int          fails;

		function new(int unsigned pwm_period);
			ramp_up    = 60;
			ramp_down  = 60;
			hold_len   = 30;
			dark_len   = 150;
			full_scale = '{1024, 1024, 1024};
			duty_cap   = (pwm_period - 1 > 1023) ? 1023 : pwm_period - 1;
			running    = 0;
			step_no    = 0;
			ticks_left = 0;
			col_r      = 0;
			col_g      = 0;
			col_b      = 0;
			fails      = 0;
		endfunction

		function void write_reg(reg_idx_t idx, int unsigned val);
			case (idx)
				REG_RAMP_IN:   ramp_up  = val & 32'hFF;
				REG_RAMP_OUT:  ramp_down = val & 32'hFF;
				REG_HOLD:      hold_len = val & 32'hFFFF;
				REG_WAIT:      dark_len = val & 32'hFFFF;
				REG_RED_CAL:   full_scale[0] = val & 32'h7FF;
				REG_GREEN_CAL: full_scale[1] = val & 32'h7FF;
				REG_BLUE_CAL:  full_scale[2] = val & 32'h7FF;
				default: ;
			endcase
		endfunction

		function int pending();
			return duties_due.size();
		endfunction

		// Scale one level onto the calibrated compare range, saturate at the cap
		function logic [DUTY_W-1:0] to_duty(int unsigned lvl, int unsigned cal);
			int unsigned c, d;
			c = (cal == 0) ? 1 : cal;
			d = (lvl * (c - 1)) / int'(LEVEL_MAX);
			if (d > duty_cap)
				d = duty_cap;
			return DUTY_W'(d);
		endfunction

		function void push_levels(int unsigned r, int unsigned g, int unsigned b);
			out_item_t res;
			res.red_duty   = to_duty(r, full_scale[0]);
			res.green_duty = to_duty(g, full_scale[1]);
			res.blue_duty  = to_duty(b, full_scale[2]);
			res.lit        = (r != 0) || (g != 0) || (b != 0);
			duties_due.push_back(res);
		endfunction

		// One animation step: rise, full, fall, then dark with a restart
		function void advance_envelope();
			int unsigned c, k, r, g, b;
			c = step_no;
			if (c < ramp_up) begin
				r = col_r * c / ramp_up;
				g = col_g * c / ramp_up;
				b = col_b * c / ramp_up;
				ticks_left = 1;
			end else if (c == ramp_up) begin
				r = col_r;
				g = col_g;
				b = col_b;
				ticks_left = (hold_len == 0) ? 1 : hold_len;
			end else if (c <= ramp_up + ramp_down) begin
				k = ramp_up + ramp_down - c;
				r = col_r * k / ramp_down;
				g = col_g * k / ramp_down;
				b = col_b * k / ramp_down;
				ticks_left = 1;
			end else begin
				step_no = 0;
				ticks_left = (dark_len == 0) ? 1 : dark_len;
				push_levels(0, 0, 0);
				return;
			end
			push_levels(r, g, b);
			step_no = (step_no + 1) & 32'h1FF;
		endfunction

		// Note an accepted beat; returns 0 when the block has nothing to do with it
		function bit note_beat(in_item_t beat);
			if (beat.kind == KIND_COLOUR) begin
				step_no = 0;
				if (beat.red_level == 0 && beat.green_level == 0 && beat.blue_level == 0) begin
					running = 0;
					ticks_left = 0;
					push_levels(0, 0, 0);
				end else begin
					col_r = beat.red_level;
					col_g = beat.green_level;
					col_b = beat.blue_level;
					running = 1;
					advance_envelope();
				end
				return 1;
			end
			if (!running)
				return 0;
			if (ticks_left > 1)
				ticks_left--;
			else
				advance_envelope();
			return 1;
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				fails++;
			end
		endfunction

		function void check_duties(out_item_t got);
			out_item_t want;
			if (duties_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				fails++;
				return;
			end
			want = duties_due.pop_front();
			compare_field("red_duty", want.red_duty, got.red_duty);
			compare_field("green_duty", want.green_duty, got.green_duty);
			compare_field("blue_duty", want.blue_duty, got.blue_duty);
			compare_field("lit", want.lit, got.lit);
		endfunction
	endclass

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              psel      = 1'b0;
	logic              penable   = 1'b0;
	logic              pwrite    = 1'b0;
	logic [ADDR_W-1:0] paddr     = '0;
	logic [DATA_W-1:0] pwdata    = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	in_item_t          in_data   = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	out_item_t         out_data;

	envelope_board envelope = new(PWM_PERIOD);
	int            live_beats  = 0;
	int            idle_cycles = 0;
	int            stall_left  = 0;
	bit            eager       = 0;

	breathing_rgb_led_envelope #(.PWM_PERIOD(PWM_PERIOD)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always #2 clk = ~clk;

	// Receiver: alternate free and stalled stretches of random length
	always @(posedge clk) begin : stall_gen
		int roll;
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 45) begin
				out_stall  <= 1'b0;
				stall_left <= $urandom_range(0, 5);
			end else if (roll < 75) begin
				out_stall  <= 1'b1;
				stall_left <= $urandom_range(0, 2);
			end else if (roll < 83) begin
				out_stall  <= 1'b1;
				stall_left <= $urandom_range(15, 80);
			end else begin
				out_stall  <= 1'b0;
				stall_left <= $urandom_range(40, 300);
			end
		end
	end

	// Check every result beat against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			envelope.check_duties(out_data);
	end

	// Abort when neither channel moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("breathing_rgb_led_envelope verification failed");
			$finish;
		end
	end

	function int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 60);
	endfunction

	// Present one beat, hold it until accepted, then note it
	task send_beat(in_item_t beat);
		int gap;
		gap = eager ? 0 : pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= beat;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (envelope.note_beat(beat))
			live_beats++;
	endtask

	task send_colour(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		in_item_t beat;
		beat.kind        = KIND_COLOUR;
		beat.red_level   = r;
		beat.green_level = g;
		beat.blue_level  = b;
		send_beat(beat);
	endtask

	task send_tick();
		in_item_t beat;
		beat.kind        = KIND_TICK;
		beat.red_level   = 8'($urandom);
		beat.green_level = 8'($urandom);
		beat.blue_level  = 8'($urandom);
		send_beat(beat);
	endtask

	function in_item_t random_colour();
		in_item_t beat;
		int       roll;
		logic [7:0] picks [4];
		picks = '{8'h00, 8'h01, 8'h80, 8'hFF};
		roll = $urandom_range(0, 99);
		beat.kind        = KIND_COLOUR;
		beat.red_level   = 8'($urandom);
		beat.green_level = 8'($urandom);
		beat.blue_level  = 8'($urandom);
		if (roll >= 60 && roll < 75) begin
			case ($urandom_range(0, 2))
				0: beat.red_level = '0;
				1: beat.green_level = '0;
				default: beat.blue_level = '0;
			endcase
		end else if (roll >= 75 && roll < 85) begin
			beat.red_level   = picks[$urandom_range(0, 3)];
			beat.green_level = picks[$urandom_range(0, 3)];
			beat.blue_level  = picks[$urandom_range(0, 3)];
		end else if (roll >= 85) begin
			beat.red_level   = '0;
			beat.green_level = '0;
			beat.blue_level  = '0;
			case ($urandom_range(0, 2))
				0: beat.red_level = 8'($urandom_range(1, 255));
				1: beat.green_level = 8'($urandom_range(1, 255));
				default: beat.blue_level = 8'($urandom_range(1, 255));
			endcase
		end
		return beat;
	endfunction

	// Drop valid and hold until every predicted result has left the block
	task drain_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (envelope.pending() != 0);
	endtask

	// Setup then access; psel stays high across back-to-back writes
	task apb_write(reg_idx_t idx, int unsigned val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		envelope.write_reg(idx, val);
	endtask

	// Reconfigure only once the block is idle
	task apply_settings(int unsigned up, int unsigned down, int unsigned hold,
		int unsigned dark, int unsigned cal_r, int unsigned cal_g, int unsigned cal_b);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		apb_write(REG_RAMP_IN, up);
		apb_write(REG_RAMP_OUT, down);
		apb_write(REG_HOLD, hold);
		apb_write(REG_WAIT, dark);
		apb_write(REG_RED_CAL, cal_r);
		apb_write(REG_GREEN_CAL, cal_g);
		apb_write(REG_BLUE_CAL, cal_b);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	function int unsigned pick_ramp();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return $urandom_range(1, 6);
		if (roll < 80)
			return 0;
		if (roll < 90)
			return 255;
		return $urandom_range(0, 255);
	endfunction

	function int unsigned pick_ticks();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return $urandom_range(1, 4);
		if (roll < 80)
			return 0;
		if (roll < 90)
			return 65535;
		return $urandom_range(0, 65535);
	endfunction

	function int unsigned pick_scale();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return $urandom_range(1, 1024);
		if (roll < 75)
			return 1024;
		if (roll < 85)
			return $urandom_range(0, 1);
		return $urandom_range(0, 2047);
	endfunction

	initial begin
		int unsigned up, down, hold, dark, cycle_len, run_len;
		int          goal, roll;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: tick while stopped, color starts at level zero, zero color stops
		send_tick();
		send_colour(8'hFF, 8'hFF, 8'hFF);
		send_tick();
		send_colour(8'h55, 8'hAA, 8'h01);
		send_tick();
		send_colour(8'h00, 8'h00, 8'h00);
		send_tick();

		// Shortest ramps and waits; saturating and zero calibration
		apply_settings(1, 1, 1, 1, 1024, 2047, 0);
		send_colour(8'hFF, 8'h80, 8'hFF);
		repeat (5) send_tick();
		send_colour(8'hAA, 8'h55, 8'h7F);

		// Zero ramps, hold and wait: ramps skipped, next tick takes the step
		apply_settings(0, 0, 0, 0, 1, 1, 1);
		send_colour(8'd200, 8'd100, 8'd50);
		repeat (4) send_tick();

		// Longest ramps and waits
		apply_settings(255, 255, 65535, 65535, 1, 1024, 1);
		send_colour(8'hFF, 8'hFF, 8'hFF);
		repeat (3) send_tick();

		// Random phases: color followed by a run of ticks, with some noise
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			up   = pick_ramp();
			down = pick_ramp();
			hold = pick_ticks();
			dark = pick_ticks();
			apply_settings(up, down, hold, dark, pick_scale(), pick_scale(), pick_scale());
			eager = ($urandom_range(0, 3) == 0);
			cycle_len = up + down + 2 + (hold == 0 ? 1 : hold) + (dark == 0 ? 1 : dark);
			if (cycle_len > 100)
				cycle_len = 100;
			goal = live_beats + PHASE_BEATS;
			while (live_beats < goal) begin
				roll = $urandom_range(0, 99);
				if (roll < 72) begin
					send_beat(random_colour());
					run_len = $urandom_range(1, 2 * cycle_len);
					// Keep the phase near its beat budget
					if (live_beats + int'(run_len) > goal)
						run_len = (goal > live_beats) ? unsigned'(goal - live_beats) : 32'd0;
					repeat (run_len) send_tick();
				end else if (roll < 82) begin
					send_colour(8'h00, 8'h00, 8'h00);
					repeat ($urandom_range(1, 4)) send_tick();
				end else if (roll < 96) begin
					if ($urandom_range(0, 1))
						send_tick();
					else
						send_beat(random_colour());
				end else begin
					drain_results();
				end
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (envelope.fails == 0 && envelope.pending() == 0)
			$display("breathing_rgb_led_envelope verification clean");
		else
			$display("breathing_rgb_led_envelope verification failed");
		$finish;
	end

endmodule
